### hdl/assert_macros.svh
// Assertion helpers for the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// The expression must never be true out of reset.
`define ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

### hdl/fbkr_pkg.sv
package fbkr_pkg;

  // Number of key fields in a request; the request struct carries four keys.
  localparam int MAX_KEYS  = 4;
  // Header is two words, each key slot is two words.
  localparam int NUM_WORDS = 2 + 2 * MAX_KEYS;
  localparam int WCNT_W    = $clog2(NUM_WORDS + 1);
  // One remainder step per dividend bit.
  localparam int DIV_STEPS = 64;

  localparam logic [31:0] HASH_SEED = 32'd42;
  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] MIX_ADD   = 32'he6546b64;
  localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [1:0] CFG_BUCKET_MODE  = 2'd1;
  localparam logic [1:0] CFG_KEY_COUNT    = 2'd2;
  localparam logic [1:0] CFG_KEY_WIDTHS   = 2'd3;

  // Key width codes.
  localparam logic [1:0] KW_BYTE1 = 2'd0;
  localparam logic [1:0] KW_BYTE2 = 2'd1;
  localparam logic [1:0] KW_BYTE4 = 2'd2;
  localparam logic [1:0] KW_BYTE8 = 2'd3;

  typedef struct packed {
    logic signed [63:0] key_0;
    logic signed [63:0] key_1;
    logic signed [63:0] key_2;
    logic signed [63:0] key_3;
    logic [3:0]         null_mask;
  } request_t;

  typedef struct packed {
    logic [30:0] bucket;
    logic        mode_error;
  } result_t;

  // Bus that runs through the front stages and the hash chain.
  typedef struct packed {
    logic                        valid;
    logic                        hash_mode;
    logic                        err;
    logic                        neg;
    logic [63:0]                 mag;
    logic [WCNT_W-1:0]           nwords;
    logic [WCNT_W-1:0]           remain;
    logic [31:0]                 h;
    logic [NUM_WORDS-1:0][31:0]  k;
  } mix_bus_t;

  // Bus that runs through the remainder chain.
  typedef struct packed {
    logic        valid;
    logic        err;
    logic        neg;
    logic [30:0] rem;
    logic [63:0] dvd;
  } div_bus_t;

endpackage

### hdl/fixed_bucket_key_router.sv
// Throughput: one request per cycle; busy is always low.
// The pipeline runs through front stages, the hash chain (one cell per row word),
// finish stages and the 64-cell remainder chain (one dividend bit per cell).
// Synchronous reset clears the configuration to its defaults and empties the pipeline.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fixed_bucket_key_router
  import fbkr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  logic [30:0] bucket_count;
  logic        bucket_mode;
  logic [2:0]  key_count;
  logic [7:0]  key_widths;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 31'd1;
      bucket_mode  <= 1'b0;
      key_count    <= 3'd1;
      key_widths   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUCKET_COUNT: bucket_count <= cfg_data[30:0];
        CFG_BUCKET_MODE:  bucket_mode  <= cfg_data[0];
        CFG_KEY_COUNT:    key_count    <= cfg_data[2:0];
        CFG_KEY_WIDTHS:   key_widths   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [30:0] divisor;
  assign divisor = (bucket_count == '0) ? 31'd1 : bucket_count;

  function automatic logic [63:0] width_mask(input logic [1:0] code);
    logic [63:0] m;
    unique case (code)
      KW_BYTE1: m = 64'h0000_0000_0000_00ff;
      KW_BYTE2: m = 64'h0000_0000_0000_ffff;
      KW_BYTE4: m = 64'h0000_0000_ffff_ffff;
      default:  m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // Pack the row into words and prepare the single-key modulo operand.
  logic [MAX_KEYS-1:0][63:0] keys;
  logic [2:0]        nkeys;
  logic [7:0]        null_byte;
  logic [63:0]       slot;
  logic [63:0]       v;
  logic [63:0]       k0;
  mix_bus_t          p0_next;

  always_comb begin
    keys[0] = request.key_0;
    keys[1] = request.key_1;
    keys[2] = request.key_2;
    keys[3] = request.key_3;
    nkeys = (key_count > 3'(MAX_KEYS)) ? 3'(MAX_KEYS) : key_count;
    null_byte = '0;
    p0_next = '0;
    p0_next.valid = start && !busy;
    p0_next.hash_mode = !bucket_mode;
    p0_next.err = bucket_mode && (key_count != 3'd1);
    p0_next.nwords = WCNT_W'(2) + WCNT_W'({nkeys, 1'b0});
    for (int i = 0; i < MAX_KEYS; i++) begin
      slot = '0;
      if (3'(i) < nkeys) begin
        null_byte[i] = request.null_mask[i];
        if (!request.null_mask[i]) begin
          slot = keys[i] & width_mask(key_widths[2*i +: 2]);
        end
      end
      p0_next.k[2 + 2*i] = slot[31:0];
      p0_next.k[3 + 2*i] = slot[63:32];
    end
    p0_next.k[0] = {16'h0, null_byte, 8'h0};
    p0_next.k[1] = '0;
    // Key 0 cut to its column width and sign extended; null reads as zero.
    k0 = keys[0];
    unique case (key_widths[1:0])
      KW_BYTE1: v = {{56{k0[7]}}, k0[7:0]};
      KW_BYTE2: v = {{48{k0[15]}}, k0[15:0]};
      KW_BYTE4: v = {{32{k0[31]}}, k0[31:0]};
      default:  v = k0;
    endcase
    if (request.null_mask[0]) begin
      v = '0;
    end
    p0_next.neg = v[63];
    p0_next.mag = v[63] ? (~v + 64'd1) : v;
  end

  mix_bus_t p0, p1, p2;
  mix_bus_t p1_next, p2_next;

  // Per-word key mixing, two multiplier stages over all words in parallel.
  always_comb begin
    p1_next = p0;
    for (int j = 0; j < NUM_WORDS; j++) begin
      p1_next.k[j] = p0.k[j] * MIX_C1;
    end
    p2_next = p1;
    p2_next.h = HASH_SEED;
    p2_next.remain = p1.nwords;
    for (int j = 0; j < NUM_WORDS; j++) begin
      p2_next.k[j] = {p1.k[j][16:0], p1.k[j][31:17]} * MIX_C2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0.valid <= 1'b0;
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
    end else begin
      p0 <= p0_next;
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  // Hash chain: one cell per row word.
  mix_bus_t chain [0:NUM_WORDS];
  assign chain[0] = p2;

  for (genvar c = 0; c < NUM_WORDS; c++) begin : g_mix
    fbkr_mix_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bus_in  (chain[c]),
      .bus_out (chain[c+1])
    );
  end

  // Hash finish: length, then two multiply rounds.
  mix_bus_t f1, f2, f1_next, f2_next;
  logic [31:0] a1, a2, a3, mag32;
  div_bus_t d0, d0_next;

  always_comb begin
    a1 = chain[NUM_WORDS].h ^ {{(30 - WCNT_W){1'b0}}, chain[NUM_WORDS].nwords, 2'b00};
    a1 = a1 ^ (a1 >> 16);
    f1_next = chain[NUM_WORDS];
    f1_next.h = a1 * FIN_C1;
    a2 = f1.h ^ (f1.h >> 13);
    f2_next = f1;
    f2_next.h = a2 * FIN_C2;
    a3 = f2.h ^ (f2.h >> 16);
    mag32 = a3[31] ? (~a3 + 32'd1) : a3;
    d0_next.valid = f2.valid;
    d0_next.err = f2.err;
    d0_next.neg = f2.hash_mode ? 1'b0 : f2.neg;
    d0_next.rem = '0;
    d0_next.dvd = f2.hash_mode ? {32'h0, mag32} : f2.mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1.valid <= 1'b0;
      f2.valid <= 1'b0;
      d0.valid <= 1'b0;
    end else begin
      f1 <= f1_next;
      f2 <= f2_next;
      d0 <= d0_next;
    end
  end

  // Remainder chain: one cell per dividend bit.
  div_bus_t dchain [0:DIV_STEPS];
  assign dchain[0] = d0;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    fbkr_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .divisor (divisor),
      .bus_in  (dchain[s]),
      .bus_out (dchain[s+1])
    );
  end

  // Result: floor correction for negative keys, zero on mode error.
  result_t result_next;
  logic [30:0] r;

  always_comb begin
    r = dchain[DIV_STEPS].rem;
    result_next.mode_error = dchain[DIV_STEPS].err;
    if (dchain[DIV_STEPS].err) begin
      result_next.bucket = '0;
    end else if (dchain[DIV_STEPS].neg && (r != '0)) begin
      result_next.bucket = divisor - r;
    end else begin
      result_next.bucket = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dchain[DIV_STEPS].valid;
    end
    result <= result_next;
  end

  // Checks on the delivered results.
  `ASSERT_IMP(a_bucket_in_range, done && !result.mode_error, result.bucket < divisor)
  `ASSERT_IMP(a_error_zero_bucket, done && result.mode_error, result.bucket == '0)
  `ASSERT_NEVER(a_error_in_hash_mode, done && result.mode_error && !bucket_mode)

endmodule

### hdl/fbkr_mix_cell.sv
module fbkr_mix_cell
  import fbkr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mix_bus_t bus_in,
  output mix_bus_t bus_out
);

  mix_bus_t bus_next;
  logic [31:0] x;
  logic [31:0] r;

  // One hash round on the front word while words remain, then shift the words down.
  always_comb begin
    x = bus_in.h ^ bus_in.k[0];
    r = {x[18:0], x[31:19]};
    bus_next = bus_in;
    bus_next.k = bus_in.k >> 32;
    if (bus_in.remain != '0) begin
      bus_next.h = (r << 2) + r + MIX_ADD;
      bus_next.remain = bus_in.remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out <= bus_next;
    end
  end

endmodule

### hdl/fbkr_div_cell.sv
module fbkr_div_cell
  import fbkr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] divisor,
  input  div_bus_t    bus_in,
  output div_bus_t    bus_out
);

  div_bus_t bus_next;
  logic [31:0] t;
  logic [31:0] diff;

  // One restoring remainder step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    t = {bus_in.rem, bus_in.dvd[63]};
    diff = t - {1'b0, divisor};
    bus_next = bus_in;
    bus_next.dvd = {bus_in.dvd[62:0], 1'b0};
    bus_next.rem = (t >= {1'b0, divisor}) ? diff[30:0] : t[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out <= bus_next;
    end
  end

endmodule
